// ===== src/upr_pkg.sv =====
// Shared types, constants and ring helpers for the UART packet ring buffers.
package upr_pkg;

  localparam int RING_DEPTH = 32;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int SUM_W      = 10;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    CMD_RX_BYTE  = 2'd0,
    CMD_TX_READY = 2'd1,
    CMD_WRITE    = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_RX_DROP  = 3'd1,
    ST_TX_BYTE  = 3'd2,
    ST_TX_IDLE  = 3'd3,
    ST_WR_OK    = 3'd4,
    ST_WR_REJ   = 3'd5,
    ST_PKT_BYTE = 3'd6,
    ST_NO_PKT   = 3'd7
  } status_t;

  typedef struct packed {
    logic load_item;
    logic exec_simple;
    logic emit_no_pkt;
    logic fetch_len;
    logic start_stream;
    logic send_byte;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic rx_short;
    logic len_bad;
    logic slot_free;
    logic last_byte;
  } dp_status_t;

  function automatic ptr_t ring_next(input ptr_t p);
    if (p == ptr_t'(RING_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic ptr_t ring_used(input ptr_t head, input ptr_t tail);
    logic [PTR_W:0] wrapped;
    wrapped = {1'b0, tail} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, head};
    if (tail >= head) begin
      return tail - head;
    end
    return wrapped[PTR_W-1:0];
  endfunction

endpackage

// ===== src/upr_ctrl.sv =====
// Controller state machine that sequences each beat through the datapath.
module upr_ctrl
  import upr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_LEN  = 4'b0100,
    S_SEND = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_read) begin
          if (sts.rx_short) begin
            if (sts.slot_free) begin
              cmd.emit_no_pkt = 1'b1;
              state_nxt       = S_IDLE;
            end
          end else begin
            cmd.fetch_len = 1'b1;
            state_nxt     = S_LEN;
          end
        end else if (sts.slot_free) begin
          cmd.exec_simple = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_LEN: begin
        if (sts.len_bad) begin
          if (sts.slot_free) begin
            cmd.emit_no_pkt = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            cmd.fetch_len = 1'b1;
          end
        end else begin
          cmd.start_stream = 1'b1;
          state_nxt        = S_SEND;
        end
      end
      S_SEND: begin
        if (sts.slot_free) begin
          cmd.send_byte = 1'b1;
          if (sts.last_byte) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== src/upr_dpath.sv =====
// Datapath with both byte rings, their pointers, write tracking and the output register.
module upr_dpath
  import upr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] in_command,
  input  logic [7:0] in_data,
  input  logic [7:0] in_packet_length,
  input  logic       in_first_of_packet,
  input  ctrl_cmd_t  cmd,
  output dp_status_t sts,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_data_res,
  output logic       out_last
);

  logic [7:0] rx_mem [RING_DEPTH];
  logic [7:0] tx_mem [RING_DEPTH];

  cmd_t       item_cmd_r;
  logic [7:0] item_data_r;
  logic [7:0] item_plen_r;
  logic       item_first_r;

  ptr_t       rx_head_r, rx_head_nxt;
  ptr_t       rx_tail_r, rx_tail_nxt;
  ptr_t       tx_head_r, tx_head_nxt;
  ptr_t       tx_tail_r, tx_tail_nxt;
  logic       tx_en_r, tx_en_nxt;
  logic       wacc_r, wacc_nxt;
  logic [7:0] wrem_r, wrem_nxt;
  ptr_t       rd_ptr_r, rd_ptr_nxt;
  ptr_t       rd_cnt_r, rd_cnt_nxt;

  logic [7:0] rx_rd_r;
  logic [7:0] tx_rd_r;
  ptr_t       rx_raddr;

  logic       rx_we;
  logic       tx_we;

  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r, out_status_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;

  ptr_t       rx_used;
  ptr_t       tx_used;
  logic [8:0] pkt_len;
  logic [SUM_W-1:0] room_need;
  logic       wr_reject;

  assign rx_used   = ring_used(rx_head_r, rx_tail_r);
  assign tx_used   = ring_used(tx_head_r, tx_tail_r);
  assign pkt_len   = {1'b0, rx_rd_r} + 9'd2;
  assign room_need = SUM_W'(item_plen_r) + SUM_W'(tx_used);
  assign wr_reject = room_need > SUM_W'(RING_DEPTH - 2);

  assign sts.is_read   = (item_cmd_r == CMD_READ);
  assign sts.rx_short  = (rx_used < ptr_t'(2));
  assign sts.len_bad   = (pkt_len > 9'(rx_used));
  assign sts.slot_free = !out_valid_r || !out_stall;
  assign sts.last_byte = (rd_cnt_r == ptr_t'(1));

  always_comb begin
    priority if (cmd.fetch_len) begin
      rx_raddr = ring_next(rx_head_r);
    end else if (cmd.start_stream) begin
      rx_raddr = rx_head_r;
    end else if (cmd.send_byte) begin
      rx_raddr = ring_next(rd_ptr_r);
    end else begin
      rx_raddr = rd_ptr_r;
    end
  end

  always_comb begin
    rx_head_nxt    = rx_head_r;
    rx_tail_nxt    = rx_tail_r;
    tx_head_nxt    = tx_head_r;
    tx_tail_nxt    = tx_tail_r;
    tx_en_nxt      = tx_en_r;
    wacc_nxt       = wacc_r;
    wrem_nxt       = wrem_r;
    rd_ptr_nxt     = rd_ptr_r;
    rd_cnt_nxt     = rd_cnt_r;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;

    if (cmd.exec_simple || cmd.emit_no_pkt || cmd.send_byte) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_last_nxt  = 1'b1;
    end

    if (cmd.emit_no_pkt) begin
      out_status_nxt = ST_NO_PKT;
    end

    if (cmd.start_stream) begin
      rd_ptr_nxt = rx_head_r;
      rd_cnt_nxt = pkt_len[PTR_W-1:0];
    end

    if (cmd.send_byte) begin
      out_status_nxt = ST_PKT_BYTE;
      out_data_nxt   = rx_rd_r;
      out_last_nxt   = sts.last_byte;
      rd_ptr_nxt     = ring_next(rd_ptr_r);
      rd_cnt_nxt     = rd_cnt_r - 1'b1;
      if (sts.last_byte) begin
        rx_head_nxt = ring_next(rd_ptr_r);
      end
    end

    if (cmd.exec_simple) begin
      unique case (item_cmd_r)
        CMD_RX_BYTE: begin
          if (ring_next(rx_tail_r) == rx_head_r) begin
            out_status_nxt = ST_RX_DROP;
          end else begin
            rx_we          = 1'b1;
            rx_tail_nxt    = ring_next(rx_tail_r);
            out_status_nxt = ST_STORED;
          end
        end
        CMD_TX_READY: begin
          out_status_nxt = ST_TX_IDLE;
          if (tx_en_r) begin
            if (tx_head_r != tx_tail_r) begin
              out_status_nxt = ST_TX_BYTE;
              out_data_nxt   = tx_rd_r;
              tx_head_nxt    = ring_next(tx_head_r);
            end else begin
              tx_en_nxt = 1'b0;
            end
          end
        end
        CMD_WRITE: begin
          if (item_first_r) begin
            if (wr_reject) begin
              wacc_nxt       = 1'b0;
              wrem_nxt       = '0;
              out_status_nxt = ST_WR_REJ;
            end else begin
              tx_en_nxt      = 1'b1;
              out_status_nxt = ST_WR_OK;
              if (item_plen_r == 8'd0) begin
                wacc_nxt = 1'b0;
                wrem_nxt = '0;
              end else begin
                tx_we       = 1'b1;
                tx_tail_nxt = ring_next(tx_tail_r);
                wrem_nxt    = item_plen_r - 8'd1;
                wacc_nxt    = (item_plen_r != 8'd1);
              end
            end
          end else if (wacc_r && (wrem_r != 8'd0)) begin
            tx_we          = 1'b1;
            tx_tail_nxt    = ring_next(tx_tail_r);
            wrem_nxt       = wrem_r - 8'd1;
            wacc_nxt       = (wrem_r != 8'd1);
            out_status_nxt = ST_WR_OK;
          end else begin
            wacc_nxt       = 1'b0;
            out_status_nxt = ST_WR_REJ;
          end
        end
        CMD_READ: begin
          out_status_nxt = ST_NO_PKT;
        end
        default: out_status_nxt = ST_NO_PKT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_tail_r] <= item_data_r;
    end
    rx_rd_r <= rx_mem[rx_raddr];
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_tail_r] <= item_data_r;
    end
    tx_rd_r <= tx_mem[tx_head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd_r   <= cmd_t'(in_command);
      item_data_r  <= in_data;
      item_plen_r  <= in_packet_length;
      item_first_r <= in_first_of_packet;
    end
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      tx_en_r     <= 1'b0;
      wacc_r      <= 1'b0;
      wrem_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rx_head_r   <= rx_head_nxt;
      rx_tail_r   <= rx_tail_nxt;
      tx_head_r   <= tx_head_nxt;
      tx_tail_r   <= tx_tail_nxt;
      tx_en_r     <= tx_en_nxt;
      wacc_r      <= wacc_nxt;
      wrem_r      <= wrem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_res = out_data_r;
  assign out_last     = out_last_r;

endmodule

// ===== src/uart_packet_ring_buffers.sv =====
// Top level of the UART packet ring buffers: controller plus datapath.
//
// One input beat carries a command: a received byte, a transmitter-ready
// event, one byte of a packet to send, or a request to read a packet.
// Every beat yields one result beat with status, data and last set, except a
// successful packet read, which yields one result beat per packet byte with
// last on the final one.
// An input beat is taken only while the controller is idle, so the block
// works on one beat at a time. A simple command goes from the idle state
// to the execute state, which issues it once the output register is free,
// and its result is then registered. A packet read goes through the execute
// state, which fetches the length from the receive memory, and the length
// state, then streams one byte per cycle while the output is not stalled.
// The result sits in an output register; while out_stall is high the result
// holds, and the controller waits with the next result before changing it.
// Reset empties both rings, disables the transmitter and clears any packet
// write in progress; the ring memories themselves are not cleared.
module uart_packet_ring_buffers
  import upr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_data,
  input  logic [7:0] in_packet_length,
  input  logic       in_first_of_packet,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_data_res,
  output logic       out_last
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  upr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  upr_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_command),
    .in_data            (in_data),
    .in_packet_length   (in_packet_length),
    .in_first_of_packet (in_first_of_packet),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_data_res       (out_data_res),
    .out_last           (out_last)
  );

endmodule
